// ===== design/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// A condition in one cycle that forces a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// A condition in one cycle that forces a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/scsa_pkg.sv =====
// Types and constants of the size-class slab allocator.
package scsa_pkg;

    localparam int DEF_NUM_CLASSES = 10;
    localparam int DEF_PAGE_BYTES  = 4096;
    localparam int DEF_STACK_DEPTH = 64;

    localparam logic [31:0] INVALID_ADDR = 32'hFFFF_FFFF;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_CLASS = 2'd1,
        ST_INVALID  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic        op;
        logic [15:0] req_size;
        logic [31:0] free_addr;
        logic [31:0] page_base;
    } req_t;

    typedef struct packed {
        logic [31:0] chunk_addr;
        status_t     status;
        logic        page_taken;
    } rsp_t;

endpackage

// ===== design/size_class_slab_allocator.sv =====
// Size-class slab allocator: top level with class selection and read-modify-write control.
// An accepted request moves the controller into execute; the result is then registered
// and strobed on done. No request is accepted while busy, which is high for the one
// execute cycle, set by the read-then-write of the class state and freed-address memories.
// Reset clears the per-class counts and valid bits at once; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle on done.
`include "assert_macros.svh"

module size_class_slab_allocator #(
    parameter int NUM_CLASSES = scsa_pkg::DEF_NUM_CLASSES,
    parameter int PAGE_BYTES  = scsa_pkg::DEF_PAGE_BYTES,
    parameter int STACK_DEPTH = scsa_pkg::DEF_STACK_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  scsa_pkg::req_t request,
    output logic          done,
    output scsa_pkg::rsp_t result
);

    // Widths derived from the parameters.
    localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int SDEPTH  = NUM_CLASSES * STACK_DEPTH;
    localparam int SA_W    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int LEFT_W  = $clog2(PAGE_BYTES / 2);
    localparam int N_W     = $clog2(PAGE_BYTES / 2 + 1);
    localparam int CS_W    = 32 + LEFT_W;

    // The controller has two states: waiting for a request, and executing one.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Captured request, class and the count that was current when it was accepted.
    logic              op_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic              cls_ok_reg;
    logic [31:0]       faddr_reg;
    logic [31:0]       pbase_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SA_W-1:0]   base_reg;

    // Freed-stack fill counts live in flip-flops so that the stack read address is known
    // in the accept cycle. The cursor and remaining-chunk count live in a small memory,
    // with one valid bit per class standing in for its reset value.
    logic [CNT_W-1:0]       count_reg [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] cls_valid_reg;

    logic                   accept;
    logic                   cls_ok;
    logic [CLS_W-1:0]       cls_sel;
    logic [CNT_W-1:0]       cnt_sel;
    logic [SA_W-1:0]        base_sel;

    logic                   stk_we;
    logic [SA_W-1:0]        stk_waddr;
    logic [SA_W-1:0]        stk_raddr;
    logic [31:0]            stk_rdata;

    logic                   cs_we;
    logic [CS_W-1:0]        cs_wdata;
    logic [CS_W-1:0]        cs_rdata;

    logic                   cnt_we;
    logic [CNT_W-1:0]       cnt_new;

    logic [31:0]            cursor;
    logic [LEFT_W-1:0]      left;
    logic [31:0]            csize;
    logic [N_W-1:0]         n_chunks;

    logic                   done_reg;
    scsa_pkg::rsp_t         rsp_reg, rsp_next;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_EXEC);
    assign done   = done_reg;
    assign result = rsp_reg;

    // Smallest class whose chunk size (two bytes shifted left by the class) covers the
    // requested size. Scanning downwards leaves the smallest match selected.
    always_comb
    begin
        cls_ok  = 1'b0;
        cls_sel = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if ((17'd2 << c) >= {1'b0, request.req_size})
            begin
                cls_ok  = 1'b1;
                cls_sel = CLS_W'(c);
            end
        end
    end

    assign cnt_sel   = count_reg[cls_sel];
    assign base_sel  = SA_W'(cls_sel * STACK_DEPTH);
    // Top of stack for a pop; the value is ignored when the stack is empty.
    assign stk_raddr = base_sel + SA_W'(cnt_sel) - SA_W'(1);
    assign stk_waddr = base_reg + SA_W'(cnt_reg);

    // The write decisions are only meaningful in the execute cycle, so both memories
    // are written only while busy.
    scsa_ram #(
        .WIDTH (32),
        .DEPTH (SDEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (busy && stk_we),
        .waddr (stk_waddr),
        .wdata (faddr_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    scsa_ram #(
        .WIDTH (CS_W),
        .DEPTH (NUM_CLASSES)
    ) u_class_ram (
        .clk   (clk),
        .we    (busy && cs_we),
        .waddr (cls_reg),
        .wdata (cs_wdata),
        .raddr (cls_sel),
        .rdata (cs_rdata)
    );

    // A class never written since reset reads as an empty page at address zero.
    assign cursor   = cls_valid_reg[cls_reg] ? cs_rdata[CS_W-1:LEFT_W] : 32'd0;
    assign left     = cls_valid_reg[cls_reg] ? cs_rdata[LEFT_W-1:0] : '0;
    assign csize    = 32'd2 << cls_reg;
    assign n_chunks = N_W'(PAGE_BYTES / 2) >> cls_reg;

    // Execute cycle: decide the outcome and form the write-back values. All memory reads
    // for this request were issued in the accept cycle and the writes land at the end of
    // this one, so the next request (accepted no earlier than the following cycle) always
    // reads the updated state and no forwarding path is needed.
    always_comb
    begin
        rsp_next.chunk_addr = 32'd0;
        rsp_next.status     = scsa_pkg::ST_OK;
        rsp_next.page_taken = 1'b0;
        stk_we   = 1'b0;
        cs_we    = 1'b0;
        cs_wdata = {cursor, left};
        cnt_we   = 1'b0;
        cnt_new  = cnt_reg;

        if (op_reg == scsa_pkg::OP_FREE)
        begin
            if (faddr_reg == scsa_pkg::INVALID_ADDR)
            begin
                rsp_next.status = scsa_pkg::ST_INVALID;
            end
            else if (!cls_ok_reg)
            begin
                rsp_next.status = scsa_pkg::ST_NO_CLASS;
            end
            else if (cnt_reg >= CNT_W'(STACK_DEPTH))
            begin
                rsp_next.status = scsa_pkg::ST_FULL;
            end
            else
            begin
                stk_we  = 1'b1;
                cnt_we  = 1'b1;
                cnt_new = cnt_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (!cls_ok_reg)
            begin
                rsp_next.status = scsa_pkg::ST_NO_CLASS;
            end
            else if (cnt_reg != '0)
            begin
                // Reuse the most recently freed chunk.
                rsp_next.chunk_addr = stk_rdata;
                cnt_we  = 1'b1;
                cnt_new = cnt_reg - CNT_W'(1);
            end
            else if (left != '0)
            begin
                // Carve the next chunk from the current page.
                rsp_next.chunk_addr = cursor;
                cs_we    = 1'b1;
                cs_wdata = {cursor + csize, left - LEFT_W'(1)};
            end
            else if (n_chunks == '0)
            begin
                // A chunk larger than a page can never be served.
                rsp_next.status = scsa_pkg::ST_NO_CLASS;
            end
            else
            begin
                // Take the supplied page, hand out its first chunk and keep the rest.
                rsp_next.chunk_addr = pbase_reg;
                rsp_next.page_taken = 1'b1;
                cs_we    = 1'b1;
                cs_wdata = {pbase_reg + csize, LEFT_W'(n_chunks - N_W'(1))};
            end
        end
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            cls_valid_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= busy;
            if (busy && cs_we)
            begin
                cls_valid_reg[cls_reg] <= 1'b1;
            end
            if (busy && cnt_we)
            begin
                count_reg[cls_reg] <= cnt_new;
            end
        end
    end

    // Request capture and result register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= request.op;
            cls_reg    <= cls_sel;
            cls_ok_reg <= cls_ok;
            faddr_reg  <= request.free_addr;
            pbase_reg  <= request.page_base;
            cnt_reg    <= cnt_sel;
            base_reg   <= base_sel;
        end
        if (busy)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // A result appears only in the cycle after an execute cycle.
    `ASSERT_IMPLIES(a_done_after_exec, clk, rst_n, done, $past(busy))
    // An accepted request always moves the controller into execution.
    `ASSERT_NEXT(a_accept_exec, clk, rst_n, start && !busy, busy)
    // A stack fill count never runs past the stack depth.
    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, busy, cnt_reg <= CNT_W'(STACK_DEPTH))
    // A consumed page always comes with a successful allocation of its base.
    `ASSERT_IMPLIES(a_page_ok, clk, rst_n, done && result.page_taken,
                    result.status == scsa_pkg::ST_OK && result.chunk_addr == pbase_reg)

endmodule

// ===== design/scsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module scsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/size_class_slab_allocator_test.sv =====
// Self-checking testbench for the size-class slab allocator.
module size_class_slab_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import scsa_pkg::*;

    localparam int          NUM_CLASSES = DEF_NUM_CLASSES;
    localparam int          STACK_DEPTH = DEF_STACK_DEPTH;
    localparam int          PAGE_BYTES  = DEF_PAGE_BYTES;
    localparam int unsigned ITEMS       = 1300;
    // The slowest legal run is each request's accept and execute plus the longest
    // sender gap and the drain pauses; this limit sits far above that.
    localparam int unsigned CYCLE_LIMIT = 400_000;

    // Shadow of the allocator state. Each accepted request is played against it
    // straight away, and the response it should produce is queued in order, so
    // that the strobed results can be compared oldest first.
    class slab_shadow;
        logic [31:0] freed_addr [NUM_CLASSES][STACK_DEPTH];
        int unsigned freed_depth [NUM_CLASSES];
        logic [31:0] cursor [NUM_CLASSES];
        int unsigned chunks_left [NUM_CLASSES];
        rsp_t        pending_rsp [$];
        int unsigned mismatches;

        function new();
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                freed_depth[c] = 0;
                cursor[c]      = '0;
                chunks_left[c] = 0;
            end
            mismatches = 0;
        endfunction

        // Smallest class whose chunk size holds the request, or -1 when none does.
        function int class_of(logic [15:0] size);
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                if ((32'd2 << c) >= {16'd0, size})
                    return c;
            end
            return -1;
        endfunction

        function void record_request(req_t r);
            rsp_t        exp_rsp;
            int          c;
            int unsigned chunks;
            logic [31:0] csize;

            exp_rsp.chunk_addr = '0;
            exp_rsp.status     = ST_OK;
            exp_rsp.page_taken = 1'b0;
            c = class_of(r.req_size);

            if (r.op == OP_FREE)
            begin
                // The invalid address is rejected before the size is even looked at.
                if (r.free_addr == INVALID_ADDR)
                    exp_rsp.status = ST_INVALID;
                else if (c < 0)
                    exp_rsp.status = ST_NO_CLASS;
                else if (freed_depth[c] >= STACK_DEPTH)
                    exp_rsp.status = ST_FULL;
                else
                begin
                    freed_addr[c][freed_depth[c]] = r.free_addr;
                    freed_depth[c]++;
                end
            end
            else if (c < 0)
            begin
                exp_rsp.status = ST_NO_CLASS;
            end
            else
            begin
                csize = 32'd2 << c;
                if (freed_depth[c] > 0)
                begin
                    freed_depth[c]--;
                    exp_rsp.chunk_addr = freed_addr[c][freed_depth[c]];
                end
                else if (chunks_left[c] > 0)
                begin
                    exp_rsp.chunk_addr = cursor[c];
                    cursor[c]          = cursor[c] + csize;   // wraps modulo 2^32
                    chunks_left[c]--;
                end
                else
                begin
                    chunks = PAGE_BYTES / csize;
                    if (chunks == 0)
                        exp_rsp.status = ST_NO_CLASS;
                    else
                    begin
                        exp_rsp.chunk_addr = r.page_base;
                        exp_rsp.page_taken = 1'b1;
                        cursor[c]          = r.page_base + csize;
                        chunks_left[c]     = chunks - 1;
                    end
                end
            end
            pending_rsp.push_back(exp_rsp);
        endfunction

        function void compare_result(rsp_t got);
            rsp_t exp_rsp;

            if (pending_rsp.size() == 0)
            begin
                $error("result with no request outstanding: chunk_addr %h status %0d page_taken %0d",
                       got.chunk_addr, got.status, got.page_taken);
                mismatches++;
                return;
            end
            exp_rsp = pending_rsp.pop_front();
            if (got.chunk_addr !== exp_rsp.chunk_addr)
            begin
                $error("chunk_addr expected %h actual %h", exp_rsp.chunk_addr, got.chunk_addr);
                mismatches++;
            end
            if (got.status !== exp_rsp.status)
            begin
                $error("status expected %0d actual %0d", exp_rsp.status, got.status);
                mismatches++;
            end
            if (got.page_taken !== exp_rsp.page_taken)
            begin
                $error("page_taken expected %0d actual %0d", exp_rsp.page_taken, got.page_taken);
                mismatches++;
            end
        endfunction
    endclass

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic start   = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    slab_shadow  shadow;
    int unsigned burst_left = 0;
    int unsigned sent       = 0;
    int unsigned cycles     = 0;

    size_class_slab_allocator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The strobe cannot be held off, so every cycle with done high is checked.
    // Signals are read just after the edge, before any of the block's updates land.
    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.compare_result(result);
    end

    function automatic req_t mk(logic op, logic [15:0] size, logic [31:0] faddr,
                                logic [31:0] pbase);
        req_t r;
        r.op        = op;
        r.req_size  = size;
        r.free_addr = faddr;
        r.page_base = pbase;
        return r;
    endfunction

    // A size that lands exactly in the given class, spread over its whole range.
    function automatic logic [15:0] size_for(int c);
        int unsigned lo;
        lo = (c == 0) ? 0 : (1 << c) + 1;
        return 16'($urandom_range(2 << c, lo));
    endfunction

    // Mostly ordinary addresses, now and then the invalid marker.
    function automatic logic [31:0] free_target();
        return ($urandom_range(0, 15) == 0) ? INVALID_ADDR : 32'($urandom());
    endfunction

    // Sends one request. The sender works in bursts: when a burst runs out, start
    // drops for a random gap, so gaps land on either phase of the accept-and-execute
    // sequence. Long bursts give stretches in which start never drops. Within a
    // burst start stays high and only the payload changes.
    task automatic issue(input req_t r);
        int unsigned gap;

        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(1, 12);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // Accepted at this edge: start was high and busy low.
        shadow.record_request(r);
        burst_left--;
        sent++;
    endtask

    // Holds the sender off until every outstanding request has been answered.
    // At least one edge passes, so start never gets two updates in one step.
    task automatic drain_all();
        start <= 1'b0;
        do
            @(posedge clk);
        while (shadow.pending_rsp.size() != 0);
    endtask

    initial
    begin
        int cls;
        int n;

        shadow = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests. Size zero and the smallest sizes go to the 2-byte class,
        // whose first allocate takes a page and whose next ones walk the cursor.
        issue(mk(OP_ALLOC, 16'd0, 32'd0, 32'h1000_0000));
        issue(mk(OP_ALLOC, 16'd2, 32'd0, 32'h7777_0000));
        issue(mk(OP_ALLOC, 16'd1, 32'hFFFF_FFFF, 32'h7777_0000));
        issue(mk(OP_ALLOC, 16'd3, 32'd0, 32'h2000_0000));
        // The largest class gets four chunks per page: use them up, then refill.
        issue(mk(OP_ALLOC, 16'd1024, 32'd0, 32'hABCD_0000));
        repeat (3) issue(mk(OP_ALLOC, 16'd1000, 32'd0, 32'h0BAD_0000));
        issue(mk(OP_ALLOC, 16'd513, 32'd0, 32'h5555_0000));
        // Sizes beyond the largest class, for both operations.
        issue(mk(OP_ALLOC, 16'd1025, 32'd0, 32'h3000_0000));
        issue(mk(OP_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        issue(mk(OP_FREE, 16'hFFFF, 32'h0000_1234, 32'd0));
        // The invalid address wins even when the size fits no class.
        issue(mk(OP_FREE, 16'd1025, INVALID_ADDR, 32'd0));
        // Frees are pushed unchecked and come back last in, first out.
        issue(mk(OP_FREE, 16'd0, 32'd0, 32'd0));
        issue(mk(OP_FREE, 16'd2, 32'hFFFF_FFFE, 32'd0));
        issue(mk(OP_ALLOC, 16'd1, 32'd0, 32'h4000_0000));
        issue(mk(OP_ALLOC, 16'd0, 32'd0, 32'h4000_0000));
        // A page just under the top of the address space: the cursor wraps to zero.
        issue(mk(OP_ALLOC, 16'd8, 32'd0, 32'hFFFF_FFF0));
        issue(mk(OP_ALLOC, 16'd5, 32'd0, 32'h6000_0000));
        issue(mk(OP_ALLOC, 16'd7, 32'd0, 32'h6000_0000));
        // A freed chunk is handed out ahead of the page cursor.
        issue(mk(OP_FREE, 16'd512, 32'hDEAD_BEEF, 32'hFFFF_FFFF));
        issue(mk(OP_ALLOC, 16'd257, 32'd0, 32'h8000_0000));

        drain_all();

        // Random part, built from short scenarios.
        while (sent < ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    // Ordinary traffic over all classes.
                    repeat (20)
                    begin
                        cls = $urandom_range(0, NUM_CLASSES - 1);
                        if ($urandom_range(0, 99) < 55)
                            issue(mk(OP_ALLOC, size_for(cls), $urandom(), $urandom()));
                        else
                            issue(mk(OP_FREE, size_for(cls), free_target(), $urandom()));
                    end
                end
                5, 6:
                begin
                    // Push one class stack to around its depth, past it in most runs so that frees are refused,
                    // then pop it to around empty, often past it so the page cursor takes over again.
                    cls = $urandom_range(0, NUM_CLASSES - 1);
                    n   = $urandom_range(60, 70);
                    repeat (n) issue(mk(OP_FREE, size_for(cls), $urandom(), $urandom()));
                    n   = $urandom_range(60, 75);
                    repeat (n) issue(mk(OP_ALLOC, size_for(cls), $urandom(), $urandom()));
                end
                7:
                begin
                    // Noise: any size, any address.
                    repeat (15)
                        issue(mk(1'($urandom()), 16'($urandom()), free_target(), $urandom()));
                end
                8:
                begin
                    drain_all();
                end
                default:
                begin
                    // Allocate runs of chunks from the large classes, enough to use up whole pages of the largest.
                    cls = $urandom_range(6, NUM_CLASSES - 1);
                    n   = $urandom_range(4, 20);
                    repeat (n) issue(mk(OP_ALLOC, size_for(cls), $urandom(), $urandom()));
                end
            endcase
        end

        // Wait for the last results, then wait on to catch any strays.
        drain_all();
        repeat (6) @(posedge clk);

        if (shadow.pending_rsp.size() != 0)
        begin
            $error("%0d expected results never arrived", shadow.pending_rsp.size());
            shadow.mismatches++;
        end

        if (shadow.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
